>>> sv/pce_pkg.sv
`default_nettype none

package pce_pkg;

  // Default capture depths
  localparam int PRE_DEPTH_DEF  = 128;
  localparam int POST_DEPTH_DEF = 128;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int IDX_W    = 8;
  localparam int REQ_W    = 2;
  localparam int PHASE_W  = 3;
  localparam int TB_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_ABORT  = 2'd3;

  // Capture phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PREFILL  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_POST     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_STRAIGHT = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_EN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_RISING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEBASE    = 2'd3;

  localparam logic [TB_W-1:0]     STRAIGHT_TIMEBASE = 4'd11;
  localparam logic [SAMPLE_W-1:0] LEVEL_RESET       = 12'd2048;

  // Source of the read data for a transaction
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_REC  = 2'd1;
  localparam logic [1:0] SRC_RING = 2'd2;

  typedef struct packed {
    logic                trig_en;
    logic [SAMPLE_W-1:0] level;
    logic                rising;
    logic [TB_W-1:0]     timebase;
  } cfg_t;

  typedef struct packed {
    logic               done;
    logic [PHASE_W-1:0] phase;
    logic [1:0]         src;
  } meta_t;

endpackage

`default_nettype wire

>>> sv/pretrigger_capture_engine.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    tuser: req_type; tdata: sample, read_index
// out_     master     out_tvalid/out_tready  tdata: read_data, capture_done, ready_lamp, phase
// cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One transaction is accepted every cycle unless the output stalls; its result passes
// the memory stage, then the output register. Each transaction makes at most one access
// to the ring or the record memory, whose read port is registered; the output register
// keeps input open while a result waits. Reset is synchronous and clears the capture
// state registers at once, no memory sweep. A stalled output holds the input after one more.

module pretrigger_capture_engine #(
  parameter int PRE_DEPTH  = pce_pkg::PRE_DEPTH_DEF,
  parameter int POST_DEPTH = pce_pkg::POST_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [1:0] req_type
  input  wire logic [pce_pkg::REQ_W-1:0]      in_tuser,
  // [11:0] sample, [19:12] read_index, [23:20] zero
  input  wire logic [pce_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [11:0] read_data, [12] capture_done, [13] ready_lamp, [16:14] phase, [23:17] zero
  output logic [pce_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pce_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int REC_LEN = PRE_DEPTH + POST_DEPTH;
  localparam int PA      = $clog2(PRE_DEPTH);
  localparam int RA      = $clog2(REC_LEN);

  pce_pkg::cfg_t cfg_r, cfg_nxt;
  pce_pkg::meta_t meta;

  logic                         acc;
  logic                         take_ready;
  logic                         ring_we, ring_re, rec_we, rec_re;
  logic [PA-1:0]                ring_waddr, ring_raddr;
  logic [RA-1:0]                rec_waddr, rec_raddr;
  logic [pce_pkg::SAMPLE_W-1:0] ring_rdata, rec_rdata;
  logic [pce_pkg::SAMPLE_W-1:0] in_sample;
  logic [pce_pkg::IDX_W-1:0]    in_idx;

  assign in_sample = in_tdata[11:0];
  assign in_idx    = in_tdata[19:12];
  assign in_tready = take_ready && rst_n;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        pce_pkg::REG_TRIG_EN:     cfg_nxt.trig_en  = cfg_data[0];
        pce_pkg::REG_TRIG_LEVEL:  cfg_nxt.level    = cfg_data[11:0];
        pce_pkg::REG_TRIG_RISING: cfg_nxt.rising   = cfg_data[0];
        pce_pkg::REG_TIMEBASE:    cfg_nxt.timebase = cfg_data[3:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_en  <= 1'b0;
      cfg_r.level    <= pce_pkg::LEVEL_RESET;
      cfg_r.rising   <= 1'b1;
      cfg_r.timebase <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pce_ctrl #(
    .PRE_DEPTH  (PRE_DEPTH),
    .POST_DEPTH (POST_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .req        (in_tuser),
    .sample     (in_sample),
    .idx        (in_idx),
    .cfg        (cfg_r),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_re    (ring_re),
    .ring_raddr (ring_raddr),
    .rec_we     (rec_we),
    .rec_waddr  (rec_waddr),
    .rec_re     (rec_re),
    .rec_raddr  (rec_raddr),
    .meta       (meta)
  );

  // Pre-trigger ring
  pce_ram #(
    .WIDTH (pce_pkg::SAMPLE_W),
    .DEPTH (PRE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (in_sample),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // Record store
  pce_ram #(
    .WIDTH (pce_pkg::SAMPLE_W),
    .DEPTH (REC_LEN)
  ) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (in_sample),
    .re    (rec_re),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  pce_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .meta       (meta),
    .ring_rdata (ring_rdata),
    .rec_rdata  (rec_rdata),
    .take_ready (take_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

>>> sv/pce_ram.sv
`default_nettype none

module pce_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/pce_ctrl.sv
`default_nettype none

module pce_ctrl #(
  parameter int PRE_DEPTH  = pce_pkg::PRE_DEPTH_DEF,
  parameter int POST_DEPTH = pce_pkg::POST_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             acc,
  input  wire logic [pce_pkg::REQ_W-1:0]        req,
  input  wire logic [pce_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic [pce_pkg::IDX_W-1:0]        idx,
  input  wire pce_pkg::cfg_t                    cfg,
  output logic                                  ring_we,
  output logic [$clog2(PRE_DEPTH)-1:0]          ring_waddr,
  output logic                                  ring_re,
  output logic [$clog2(PRE_DEPTH)-1:0]          ring_raddr,
  output logic                                  rec_we,
  output logic [$clog2(PRE_DEPTH+POST_DEPTH)-1:0] rec_waddr,
  output logic                                  rec_re,
  output logic [$clog2(PRE_DEPTH+POST_DEPTH)-1:0] rec_raddr,
  output pce_pkg::meta_t                        meta
);

  localparam int REC_LEN = PRE_DEPTH + POST_DEPTH;
  localparam int PA      = $clog2(PRE_DEPTH);
  localparam int RA      = $clog2(REC_LEN);
  localparam int FW      = $clog2(REC_LEN + 1);
  localparam int XW      = ((FW > pce_pkg::IDX_W) ? FW : pce_pkg::IDX_W) + 1;

  logic [pce_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic                         done_r, done_nxt;
  logic [FW-1:0]                fill_r, fill_nxt;
  logic [PA-1:0]                ptr_r, ptr_nxt;
  logic [PA-1:0]                start_ptr_r, start_ptr_nxt;
  logic [pce_pkg::SAMPLE_W-1:0] last_r, last_nxt;
  logic                         straight_r, straight_nxt;
  logic                         post_seen_r, post_seen_nxt;
  logic                         unrolled_r, unrolled_nxt;

  logic [FW-1:0]  fill_inc;
  logic [PA-1:0]  ptr_inc;
  logic           crossed;
  logic [XW-1:0]  idx_x;
  logic [XW-1:0]  fill_x;
  logic [PA:0]    ring_sum;
  logic [1:0]     src;

  assign fill_inc = fill_r + 1'b1;
  assign ptr_inc  = (ptr_r == PA'(PRE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  // Level crossing between the previous and the current sample
  assign crossed = cfg.rising ? ((last_r < cfg.level) && (sample >= cfg.level))
                              : ((last_r > cfg.level) && (sample <= cfg.level));

  // Unrolled ring position: oldest entry follows the trigger sample
  assign idx_x    = XW'(idx);
  assign fill_x   = XW'(fill_r);
  assign ring_sum = (PA+1)'(start_ptr_r) + (PA+1)'(idx_x);

  always_comb begin
    if (ring_sum >= (PA+1)'(PRE_DEPTH)) begin
      ring_raddr = PA'(ring_sum - (PA+1)'(PRE_DEPTH));
    end else begin
      ring_raddr = PA'(ring_sum);
    end
  end

  assign rec_raddr  = RA'(idx_x);
  assign ring_waddr = ptr_r;

  // Decode the transaction and advance the capture state
  always_comb begin
    phase_nxt     = phase_r;
    done_nxt      = done_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    start_ptr_nxt = start_ptr_r;
    last_nxt      = last_r;
    straight_nxt  = straight_r;
    post_seen_nxt = post_seen_r;
    unrolled_nxt  = unrolled_r;
    ring_we       = 1'b0;
    rec_we        = 1'b0;
    rec_waddr     = RA'(fill_r);
    src           = pce_pkg::SRC_NONE;

    if (acc) begin
      unique case (req)
        pce_pkg::REQ_START: begin
          done_nxt      = 1'b0;
          fill_nxt      = '0;
          ptr_nxt       = '0;
          post_seen_nxt = 1'b0;
          unrolled_nxt  = 1'b0;
          if (cfg.trig_en && (cfg.timebase != pce_pkg::STRAIGHT_TIMEBASE)) begin
            straight_nxt = 1'b0;
            phase_nxt    = pce_pkg::PH_PREFILL;
          end else begin
            straight_nxt = 1'b1;
            phase_nxt    = pce_pkg::PH_STRAIGHT;
          end
        end
        pce_pkg::REQ_SAMPLE: begin
          unique case (phase_r)
            pce_pkg::PH_STRAIGHT: begin
              rec_we    = 1'b1;
              rec_waddr = RA'(fill_r);
              fill_nxt  = fill_inc;
              if (fill_inc >= FW'(REC_LEN)) begin
                done_nxt  = 1'b1;
                phase_nxt = pce_pkg::PH_IDLE;
              end
            end
            pce_pkg::PH_PREFILL: begin
              ring_we  = 1'b1;
              ptr_nxt  = ptr_inc;
              last_nxt = sample;
              fill_nxt = fill_inc;
              if (fill_inc >= FW'(PRE_DEPTH)) begin
                ptr_nxt   = '0;
                phase_nxt = pce_pkg::PH_WAIT;
              end
            end
            pce_pkg::PH_WAIT: begin
              ring_we  = 1'b1;
              last_nxt = sample;
              if (crossed) begin
                fill_nxt      = '0;
                phase_nxt     = pce_pkg::PH_POST;
                post_seen_nxt = 1'b1;
                start_ptr_nxt = ptr_inc;
              end else begin
                ptr_nxt = ptr_inc;
              end
            end
            pce_pkg::PH_POST: begin
              rec_we    = 1'b1;
              rec_waddr = RA'(PRE_DEPTH) + RA'(fill_r);
              fill_nxt  = fill_inc;
              if (fill_inc >= FW'(POST_DEPTH)) begin
                done_nxt     = 1'b1;
                unrolled_nxt = 1'b1;
                phase_nxt    = pce_pkg::PH_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
        pce_pkg::REQ_READ: begin
          if (straight_r) begin
            if (idx_x < fill_x) begin
              src = pce_pkg::SRC_REC;
            end
          end else if (idx_x < XW'(PRE_DEPTH)) begin
            if (unrolled_r) begin
              src = pce_pkg::SRC_RING;
            end
          end else if (post_seen_r && (idx_x < XW'(PRE_DEPTH) + fill_x)) begin
            src = pce_pkg::SRC_REC;
          end
        end
        pce_pkg::REQ_ABORT: begin
          phase_nxt = pce_pkg::PH_IDLE;
          done_nxt  = 1'b0;
        end
      endcase
    end
  end

  assign ring_re    = (src == pce_pkg::SRC_RING);
  assign rec_re     = (src == pce_pkg::SRC_REC);
  assign meta.done  = done_nxt;
  assign meta.phase = phase_nxt;
  assign meta.src   = src;

  // Capture state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pce_pkg::PH_IDLE;
      done_r      <= 1'b0;
      fill_r      <= '0;
      ptr_r       <= '0;
      straight_r  <= 1'b1;
      post_seen_r <= 1'b0;
      unrolled_r  <= 1'b0;
      last_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      done_r      <= done_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      straight_r  <= straight_nxt;
      post_seen_r <= post_seen_nxt;
      unrolled_r  <= unrolled_nxt;
      last_r      <= last_nxt;
    end
  end

  // Trigger position, meaningful once a trigger is seen
  always_ff @(posedge clk) begin
    start_ptr_r <= start_ptr_nxt;
  end

endmodule

`default_nettype wire

>>> sv/pce_out.sv
`default_nettype none

module pce_out (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         acc,
  input  wire pce_pkg::meta_t               meta,
  input  wire logic [pce_pkg::SAMPLE_W-1:0] ring_rdata,
  input  wire logic [pce_pkg::SAMPLE_W-1:0] rec_rdata,
  output logic                              take_ready,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [pce_pkg::OUT_DATA_W-1:0]    out_tdata
);

  logic                         s1_valid_r, s1_valid_nxt;
  pce_pkg::meta_t               s1_meta_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [pce_pkg::SAMPLE_W-1:0] out_rd_r;
  logic                         out_done_r;
  logic                         out_lamp_r;
  logic [pce_pkg::PHASE_W-1:0]  out_phase_r;
  logic                         s1_adv;
  logic [pce_pkg::SAMPLE_W-1:0] s1_rd;

  // Advance the memory stage when the output register is free
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign take_ready    = !s1_valid_r || s1_adv;
  assign s1_valid_nxt  = acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_tready);

  // Select the read data for the transaction in the memory stage
  always_comb begin
    case (s1_meta_r.src)
      pce_pkg::SRC_REC:  s1_rd = rec_rdata;
      pce_pkg::SRC_RING: s1_rd = ring_rdata;
      default:           s1_rd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payloads until the next stage takes them
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_meta_r <= meta;
    end
    if (s1_adv) begin
      out_rd_r    <= s1_rd;
      out_done_r  <= s1_meta_r.done;
      out_phase_r <= s1_meta_r.phase;
      out_lamp_r  <= (s1_meta_r.phase == pce_pkg::PH_WAIT) ||
                     (s1_meta_r.phase == pce_pkg::PH_STRAIGHT);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_phase_r, out_lamp_r, out_done_r, out_rd_r};

endmodule

`default_nettype wire

>>> tb/pretrigger_capture_engine_tb.sv
`timescale 1ns / 1ps

typedef logic [pce_pkg::SAMPLE_W-1:0]   sample_t;
typedef logic [pce_pkg::IDX_W-1:0]      index_t;
typedef logic [pce_pkg::TB_W-1:0]       tbase_t;
typedef logic [pce_pkg::CFG_DATA_W-1:0] cfg_word_t;

// One result word as it appears in out_tdata[16:0], lowest field last
typedef struct packed {
  logic [pce_pkg::PHASE_W-1:0]  phase;
  logic                         lamp;
  logic                         done;
  logic [pce_pkg::SAMPLE_W-1:0] rdata;
} scope_result_t;

// Capture predictor and queue of expected results
class capture_scoreboard;
  bit                         trig_en;
  bit [pce_pkg::SAMPLE_W-1:0] level;
  bit                         rising;
  bit [pce_pkg::TB_W-1:0]     tbase;

  bit [pce_pkg::SAMPLE_W-1:0] ring [pce_pkg::PRE_DEPTH_DEF];
  bit [pce_pkg::SAMPLE_W-1:0] rec [pce_pkg::PRE_DEPTH_DEF + pce_pkg::POST_DEPTH_DEF];
  int                         ring_ptr;
  int                         fill;
  bit [pce_pkg::SAMPLE_W-1:0] prev_smp;
  logic [pce_pkg::PHASE_W-1:0] phase;
  bit                         done;

  int                errors;
  scope_result_t     expected_q[$];

  function new();
    level = pce_pkg::LEVEL_RESET;
    rising = 1'b1;
    phase = pce_pkg::PH_IDLE;
  endfunction

  function void write_reg(logic [pce_pkg::CFG_IDX_W-1:0] idx,
                          logic [pce_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      pce_pkg::REG_TRIG_EN:     trig_en = val[0];
      pce_pkg::REG_TRIG_LEVEL:  level = val;
      pce_pkg::REG_TRIG_RISING: rising = val[0];
      pce_pkg::REG_TIMEBASE:    tbase = val[pce_pkg::TB_W-1:0];
      default: ;
    endcase
  endfunction

  function bit crosses(bit [pce_pkg::SAMPLE_W-1:0] s);
    if (rising)
      return (prev_smp < level) && (s >= level);
    return (prev_smp > level) && (s <= level);
  endfunction

  // Advance the capture by one ADC sample
  function void store_sample(bit [pce_pkg::SAMPLE_W-1:0] s);
    case (phase)
      pce_pkg::PH_STRAIGHT: begin
        if (fill < pce_pkg::PRE_DEPTH_DEF + pce_pkg::POST_DEPTH_DEF)
          rec[fill] = s;
        fill++;
        if (fill >= pce_pkg::PRE_DEPTH_DEF + pce_pkg::POST_DEPTH_DEF) begin
          done = 1'b1;
          phase = pce_pkg::PH_IDLE;
        end
      end
      pce_pkg::PH_PREFILL: begin
        ring[ring_ptr] = s;
        ring_ptr = (ring_ptr + 1) % pce_pkg::PRE_DEPTH_DEF;
        prev_smp = s;
        fill++;
        if (fill >= pce_pkg::PRE_DEPTH_DEF) begin
          ring_ptr = 0;
          phase = pce_pkg::PH_WAIT;
        end
      end
      pce_pkg::PH_WAIT: begin
        ring[ring_ptr] = s;
        if (crosses(s)) begin
          fill = 0;
          phase = pce_pkg::PH_POST;
        end else begin
          ring_ptr = (ring_ptr + 1) % pce_pkg::PRE_DEPTH_DEF;
        end
        prev_smp = s;
      end
      pce_pkg::PH_POST: begin
        if (fill < pce_pkg::POST_DEPTH_DEF)
          rec[pce_pkg::PRE_DEPTH_DEF + fill] = s;
        fill++;
        if (fill >= pce_pkg::POST_DEPTH_DEF) begin
          // unroll the ring, oldest first, ending with the trigger sample
          for (int i = 0; i < pce_pkg::PRE_DEPTH_DEF; i++)
            rec[i] = ring[(ring_ptr + 1 + i) % pce_pkg::PRE_DEPTH_DEF];
          done = 1'b1;
          phase = pce_pkg::PH_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  function void note_request(logic [pce_pkg::REQ_W-1:0] req, sample_t s, index_t idx);
    scope_result_t res;
    res.rdata = '0;
    case (req)
      pce_pkg::REQ_START: begin
        foreach (rec[i]) rec[i] = '0;
        done = 1'b0;
        fill = 0;
        ring_ptr = 0;
        phase = (trig_en && tbase != pce_pkg::STRAIGHT_TIMEBASE) ? pce_pkg::PH_PREFILL
                                                                 : pce_pkg::PH_STRAIGHT;
      end
      pce_pkg::REQ_SAMPLE: store_sample(s);
      pce_pkg::REQ_READ: begin
        if (idx < pce_pkg::PRE_DEPTH_DEF + pce_pkg::POST_DEPTH_DEF)
          res.rdata = rec[idx];
      end
      default: begin
        phase = pce_pkg::PH_IDLE;
        done = 1'b0;
      end
    endcase
    res.done = done;
    res.lamp = (phase == pce_pkg::PH_WAIT) || (phase == pce_pkg::PH_STRAIGHT);
    res.phase = phase;
    expected_q.push_back(res);
  endfunction

  function void compare(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  function void check_result(logic [pce_pkg::OUT_DATA_W-1:0] tdata);
    scope_result_t got;
    scope_result_t want;
    got = scope_result_t'(tdata[16:0]);
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, tdata);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    compare("read_data", 32'(want.rdata), 32'(got.rdata));
    compare("capture_done", 32'(want.done), 32'(got.done));
    compare("ready_lamp", 32'(want.lamp), 32'(got.lamp));
    compare("phase", 32'(want.phase), 32'(got.phase));
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module pretrigger_capture_engine_tb;

  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int WAIT_LIMIT  = 48;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [pce_pkg::REQ_W-1:0]          in_tuser = '0;
  logic [pce_pkg::IN_DATA_W-1:0]      in_tdata = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [pce_pkg::OUT_DATA_W-1:0]     out_tdata;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [pce_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [pce_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  capture_scoreboard sb;
  int  item_count;
  int  cycle_count;
  bit  in_bursty;
  bit  out_bursty;

  pretrigger_capture_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Drive one transaction and hold it until accepted
  task automatic send_item(logic [pce_pkg::REQ_W-1:0] req, sample_t s, index_t idx);
    int gap;
    if ($urandom_range(0, 63) == 0)
      in_bursty = !in_bursty;
    gap = in_bursty ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {4'b0, idx, s};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(req, s, idx);
    item_count++;
  endtask

  // Stop sending and let every expected result drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers in one burst
  task automatic apply_settings(bit en, sample_t lvl, bit rise, tbase_t tb);
    logic [pce_pkg::CFG_IDX_W-1:0]  regs [4];
    logic [pce_pkg::CFG_DATA_W-1:0] vals [4];
    regs = '{pce_pkg::REG_TRIG_EN, pce_pkg::REG_TRIG_LEVEL, pce_pkg::REG_TRIG_RISING,
             pce_pkg::REG_TIMEBASE};
    vals = '{cfg_word_t'(en), lvl, cfg_word_t'(rise), cfg_word_t'(tb)};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_reg(regs[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic sample_t any_sample();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic index_t any_index();
    return index_t'($urandom_range(0, 255));
  endfunction

  // Samples that hover around the level so crossings come often
  function automatic sample_t near_level();
    int v;
    if ($urandom_range(0, 1) == 0)
      return sample_t'($urandom_range(0, 4095));
    v = int'(sb.level) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  // Start a capture, feed it until it completes or is aborted, with stray requests, then read back
  task automatic run_capture(bit broken);
    int r;
    int wait_len;
    wait_len = 0;
    send_item(pce_pkg::REQ_START, any_sample(), any_index());
    while (sb.phase != pce_pkg::PH_IDLE) begin
      r = $urandom_range(0, 99);
      if (r < 4)
        send_item(pce_pkg::REQ_READ, any_sample(), any_index());
      else if (broken && r < 5)
        send_item($urandom_range(0, 1) ? pce_pkg::REQ_ABORT : pce_pkg::REQ_START,
                  any_sample(), any_index());
      else if (sb.phase == pce_pkg::PH_WAIT && wait_len >= WAIT_LIMIT)
        send_item(pce_pkg::REQ_ABORT, any_sample(), any_index());
      else if (sb.phase == pce_pkg::PH_WAIT) begin
        wait_len++;
        send_item(pce_pkg::REQ_SAMPLE, near_level(), any_index());
      end else
        send_item(pce_pkg::REQ_SAMPLE, any_sample(), any_index());
    end
    // the seam between pre- and post-trigger parts, then random entries
    send_item(pce_pkg::REQ_READ, any_sample(), index_t'(pce_pkg::PRE_DEPTH_DEF - 1));
    send_item(pce_pkg::REQ_READ, any_sample(), index_t'(pce_pkg::PRE_DEPTH_DEF));
    repeat (20) send_item(pce_pkg::REQ_READ, any_sample(), any_index());
  endtask

  // Collect results under random back-pressure
  initial begin
    int stall;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0)
        out_bursty = !out_bursty;
      stall = out_bursty ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(out_tdata);
    end
  end

  initial begin
    int phase_no;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset contents, requests while idle, short straight capture, abort, restart
    send_item(pce_pkg::REQ_READ, 12'hFFF, 8'd0);
    send_item(pce_pkg::REQ_READ, 12'h000, 8'd255);
    send_item(pce_pkg::REQ_SAMPLE, 12'hFFF, 8'd255);
    send_item(pce_pkg::REQ_SAMPLE, 12'h000, 8'd0);
    send_item(pce_pkg::REQ_ABORT, 12'hABC, 8'hA5);
    send_item(pce_pkg::REQ_START, 12'h5A5, 8'h5A);
    send_item(pce_pkg::REQ_SAMPLE, 12'hFFF, 8'h00);
    send_item(pce_pkg::REQ_SAMPLE, 12'h000, 8'hFF);
    send_item(pce_pkg::REQ_SAMPLE, 12'd2048, 8'd7);
    send_item(pce_pkg::REQ_READ, 12'h000, 8'd0);
    send_item(pce_pkg::REQ_READ, 12'hFFF, 8'd1);
    send_item(pce_pkg::REQ_READ, 12'h000, 8'd2);
    send_item(pce_pkg::REQ_READ, 12'h000, 8'd3);
    send_item(pce_pkg::REQ_ABORT, 12'h000, 8'd0);
    send_item(pce_pkg::REQ_READ, 12'h000, 8'd0);
    send_item(pce_pkg::REQ_SAMPLE, 12'h123, 8'd0);
    send_item(pce_pkg::REQ_START, 12'h000, 8'd0);
    send_item(pce_pkg::REQ_READ, 12'h000, 8'd0);
    send_item(pce_pkg::REQ_SAMPLE, 12'd1, 8'd0);
    send_item(pce_pkg::REQ_START, 12'h000, 8'd0);
    send_item(pce_pkg::REQ_SAMPLE, 12'd7, 8'd0);
    send_item(pce_pkg::REQ_READ, 12'h000, 8'd0);
    send_item(pce_pkg::REQ_ABORT, 12'h000, 8'd0);
    wait_idle();

    // Full captures under several settings, fixed extremes first
    phase_no = 0;
    while (item_count < ITEM_TARGET) begin
      case (phase_no)
        0: apply_settings(1'b1, 12'd2048, 1'b1, 4'd0);
        1: apply_settings(1'b0, 12'd3000, 1'b1, 4'd5);
        2: apply_settings(1'b1, 12'd4095, 1'b1, 4'd15);
        3: apply_settings(1'b1, 12'd0, 1'b0, 4'd12);
        4: apply_settings(1'b1, 12'd1000, 1'b0, pce_pkg::STRAIGHT_TIMEBASE);
        default: apply_settings($urandom_range(0, 3) != 0,
                                sample_t'($urandom_range(0, 4095)),
                                $urandom_range(0, 1) != 0,
                                tbase_t'($urandom_range(0, 15)));
      endcase
      // stray requests while idle
      repeat ($urandom_range(0, 3))
        send_item($urandom_range(0, 1) ? pce_pkg::REQ_SAMPLE : pce_pkg::REQ_ABORT,
                  any_sample(), any_index());
      run_capture(phase_no >= 5 && $urandom_range(0, 2) == 0);
      wait_idle();
      phase_no++;
    end

    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
